[src/olssr_pkg.sv]
// Shared types and constants for the ordered list store with search and replace.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package olssr_pkg;

  // Operation codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_SEARCH  = 3'd2,
    ACT_COUNT   = 3'd3,
    ACT_REPLACE = 3'd4,
    ACT_LIST    = 3'd5,
    ACT_CLEAR   = 3'd6
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Where the position and word of a result come from.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_CUR  = 2'd1,
    SRC_PEND = 2'd2
  } emit_src_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2,
    S_FIN  = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_item;
    logic      fill_inc;
    logic      fill_dec;
    logic      fill_clr;
    logic      app_wr;
    logic      rep_wr;
    logic      rd_en;
    logic      rd_first;
    logic      idx_inc;
    logic      hit_set;
    logic      pend_load;
    logic      emit;
    emit_src_t src;
    status_t   status;
    logic      last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    full;
    logic    empty;
    logic    match;
    logic    at_end;
    logic    out_free;
    logic    pend_valid;
    logic    hit;
  } dp_stat_t;

endpackage

[src/olssr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module olssr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/olssr_dp.sv]
// Datapath: item registers, fill count, scan index, entry RAM, match logic,
// pending match and the output register. Depends on olssr_pkg and olssr_ram.
`timescale 1ns / 1ps

module olssr_dp
  import olssr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  logic [2:0]         action,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] new_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [4:0]         position,
  output logic signed [31:0] data,
  output logic [4:0]         entry_count,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  action_t               action_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [DATA_WIDTH-1:0] new_r;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic [AW-1:0]         idx;
  logic                  hit;
  logic                  pend_valid;
  logic [CW-1:0]         pend_pos;
  logic [DATA_WIDTH-1:0] pend_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CW-1:0]         cur_pos;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [CW-1:0]         sel_pos;
  logic [DATA_WIDTH-1:0] sel_data;

  // Item registers; words are kept in the low DATA_WIDTH bits.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= action_t'(action);
      key_r    <= DATA_WIDTH'(key_value);
      new_r    <= DATA_WIDTH'(new_value);
    end
  end

  // Fill count update.
  always_comb begin
    fill_next = fill;
    if (cmd.fill_clr) begin
      fill_next = '0;
    end else if (cmd.fill_inc) begin
      fill_next = fill + 1'b1;
    end else if (cmd.fill_dec) begin
      fill_next = fill - 1'b1;
    end
  end

  // Control registers: fill count, scan index, replace hit and pending match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      idx        <= '0;
      hit        <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (cmd.load_item) begin
        idx        <= '0;
        hit        <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + 1'b1;
        end
        if (cmd.hit_set) begin
          hit <= 1'b1;
        end
        if (cmd.pend_load) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // The most recent search match, held back until it is known whether it is the final one.
  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_pos  <= cur_pos;
      pend_data <= rd_data;
    end
  end

  assign cur_pos = CW'(idx) + 1'b1;

  // Entry memory: appends write at the tail, replaces write at the scan index.
  assign wr_en   = cmd.app_wr | cmd.rep_wr;
  assign wr_addr = cmd.app_wr ? AW'(fill) : idx;
  assign wr_data = cmd.app_wr ? key_r : new_r;
  assign rd_addr = cmd.rd_first ? '0 : AW'(idx + 1'b1);

  olssr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status towards the controller.
  assign stat.action     = action_r;
  assign stat.full       = (fill == CW'(DEPTH));
  assign stat.empty      = (fill == '0);
  assign stat.match      = (rd_data == key_r);
  assign stat.at_end     = (cur_pos == fill);
  assign stat.out_free   = ~out_valid | out_ready;
  assign stat.pend_valid = pend_valid;
  assign stat.hit        = hit;

  // Result source selection.
  always_comb begin
    unique case (cmd.src)
      SRC_CUR: begin
        sel_pos  = cur_pos;
        sel_data = rd_data;
      end
      SRC_PEND: begin
        sel_pos  = pend_pos;
        sel_data = pend_data;
      end
      default: begin
        sel_pos  = '0;
        sel_data = '0;
      end
    endcase
  end

  // Output register; the controller only loads it when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.status;
      position    <= 5'(sel_pos);
      data        <= 32'(signed'(sel_data));
      entry_count <= 5'(fill_next);
      last        <= cmd.last;
    end
  end

endmodule

[src/olssr_ctrl.sv]
// Controller state machine: decodes the action, steps the scan and issues
// results. Depends on olssr_pkg.
`timescale 1ns / 1ps

module olssr_ctrl
  import olssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end

      S_EXEC: begin
        cmd.last = 1'b1;
        unique case (stat.action)
          ACT_APPEND: begin
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.app_wr   = 1'b1;
                cmd.fill_inc = 1'b1;
                cmd.status   = ST_OK;
              end
            end
          end
          ACT_REMOVE: begin
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (stat.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.fill_dec = 1'b1;
                cmd.status   = ST_OK;
              end
            end
          end
          ACT_SEARCH, ACT_REPLACE, ACT_LIST: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_first = 1'b1;
              state_next   = S_SCAN;
            end
          end
          ACT_CLEAR: begin
            if (stat.out_free) begin
              cmd.fill_clr = 1'b1;
              cmd.emit     = 1'b1;
              cmd.status   = ST_OK;
              state_next   = S_IDLE;
            end
          end
          default: begin
            // Count and the unused code leave the store as it is.
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_OK;
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_SCAN: begin
        // The word at the scan index is on the RAM output in this state.
        logic proceed;
        proceed = 1'b1;
        unique case (stat.action)
          ACT_SEARCH: begin
            if (stat.match && stat.pend_valid) begin
              proceed = stat.out_free;
            end
            if (proceed && stat.match) begin
              cmd.pend_load = 1'b1;
              if (stat.pend_valid) begin
                cmd.emit   = 1'b1;
                cmd.src    = SRC_PEND;
                cmd.status = ST_OK;
              end
            end
          end
          ACT_LIST: begin
            proceed = stat.out_free;
            if (proceed) begin
              cmd.emit   = 1'b1;
              cmd.src    = SRC_CUR;
              cmd.status = ST_OK;
              cmd.last   = stat.at_end;
            end
          end
          default: begin
            // Replace overwrites each match in place.
            if (stat.match) begin
              cmd.rep_wr  = 1'b1;
              cmd.hit_set = 1'b1;
            end
          end
        endcase
        if (proceed) begin
          if (stat.at_end) begin
            state_next = (stat.action == ACT_LIST) ? S_IDLE : S_FIN;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.idx_inc = 1'b1;
          end
        end
      end

      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
          if (stat.action == ACT_SEARCH) begin
            if (stat.pend_valid) begin
              cmd.src    = SRC_PEND;
              cmd.status = ST_OK;
            end else begin
              cmd.status = ST_NOTFOUND;
            end
          end else begin
            cmd.status = stat.hit ? ST_OK : ST_NOTFOUND;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/ordered_list_store_search_replace_top.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    action, key_value, new_value
// output    out_valid / out_ready  status, position, data, entry_count, last
//
// One item is worked on at a time. Append, remove, count and clear give their
// result straight from the execute state. Search, replace and list scan the
// stored entries, visiting each once, since the entry RAM has a single registered
// read port; search and replace then give their final result from the finish state.
// Reset clears the fill count; the entry RAM needs no clearing. A held result
// stalls the scan only when a further result is due; the next item is taken
// while the last result still waits in the output register.
// Top level of the ordered list store; depends on olssr_pkg, olssr_ctrl and olssr_dp.
`timescale 1ns / 1ps

module ordered_list_store_search_replace_top
  import olssr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] new_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [4:0]         position,
  output logic signed [31:0] data,
  output logic [4:0]         entry_count,
  output logic               last
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller.
  olssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  olssr_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .key_value   (key_value),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .data        (data),
    .entry_count (entry_count),
    .last        (last)
  );

endmodule

[sim/tb_ordered_list_store_search_replace_top.sv]
// Self-checking testbench for the ordered list store with search and replace.
// Depends on olssr_pkg and ordered_list_store_search_replace_top; drives random
// and directed transfers and checks every result against its own store model.
`timescale 1ns / 1ps

module tb_ordered_list_store_search_replace_top;
  import olssr_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_PCT     = 17;
  localparam int TAIL_CYCLES  = DEPTH + 8;

  // The action code that the block leaves unused.
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // One result as it appears on the output channel.
  typedef struct {
    status_t     status;
    logic [4:0]  position;
    logic [31:0] data;
    logic [4:0]  entry_count;
    logic        last;
  } list_result_t;

  // Copy of the store, the results it predicts and the check of each result.
  class list_scoreboard;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    int unsigned           fill;
    list_result_t          expected_q [$];
    int unsigned           failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void queue_result(status_t st, int unsigned pos, logic [31:0] word,
                               bit is_last);
      list_result_t r;
      r.status      = st;
      r.position    = pos[4:0];
      r.data        = word;
      r.entry_count = fill[4:0];
      r.last        = is_last;
      expected_q.push_back(r);
    endfunction

    // Applies one accepted item to the store copy and queues its results.
    function void note_input(logic [2:0] act, logic [31:0] key, logic [31:0] repl);
      int unsigned i;
      int unsigned hits;
      hits = 0;
      case (act)
        ACT_APPEND: begin
          if (fill >= DEPTH) begin
            queue_result(ST_FULL, 0, '0, 1'b1);
          end else begin
            words[fill] = key;
            fill++;
            queue_result(ST_OK, 0, '0, 1'b1);
          end
        end
        ACT_REMOVE: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            fill--;
            queue_result(ST_OK, 0, '0, 1'b1);
          end
        end
        ACT_SEARCH: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              if (words[i] == key) begin
                queue_result(ST_OK, i + 1, words[i], 1'b0);
                hits++;
              end
            end
            if (hits == 0) begin
              queue_result(ST_NOTFOUND, 0, '0, 1'b1);
            end else begin
              expected_q[expected_q.size() - 1].last = 1'b1;
            end
          end
        end
        ACT_REPLACE: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              if (words[i] == key) begin
                words[i] = repl;
                hits++;
              end
            end
            queue_result((hits != 0) ? ST_OK : ST_NOTFOUND, 0, '0, 1'b1);
          end
        end
        ACT_LIST: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              queue_result(ST_OK, i + 1, words[i], (i + 1) == fill);
            end
          end
        end
        ACT_CLEAR: begin
          fill = 0;
          queue_result(ST_OK, 0, '0, 1'b1);
        end
        default: begin
          // Count and the unused code leave the store as it is.
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    // Compares one accepted result with the oldest waiting expectation.
    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no expectation: status %0d position %0d data %0h",
               got.status, got.position, got.data);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("position", want.position, got.position);
      compare_field("data", want.data, got.data);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = ACT_COUNT;
  logic signed [31:0] key_value = '0;
  logic signed [31:0] new_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [4:0]         position;
  logic signed [31:0] data;
  logic [4:0]         entry_count;
  logic               last;

  // Set during the stretch of the run in which neither side idles.
  bit steady_phase = 1'b0;

  list_scoreboard store_sb = new();

  ordered_list_store_search_replace_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .key_value   (key_value),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .data        (data),
    .entry_count (entry_count),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stalls at random outside the steady stretch.
  always @(posedge clk) begin
    out_ready <= !rst && (steady_phase || ($urandom_range(0, 99) >= IDLE_PCT));
  end

  // Every result transfer is checked at the edge on which it happens.
  always @(posedge clk) begin : result_monitor
    list_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.status      = status_t'(status);
      seen.position    = position;
      seen.data        = data;
      seen.entry_count = entry_count;
      seen.last        = last;
      store_sb.check_result(seen);
    end
  end

  // Presents one item, with a random gap before it, and waits for its transfer.
  task automatic send_item(logic [2:0] act, logic [31:0] key, logic [31:0] repl);
    while (!steady_phase && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    key_value <= key;
    new_value <= repl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    store_sb.note_input(act, key, repl);
  endtask

  // Holds the input side off until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (store_sb.pending() != 0) @(posedge clk);
  endtask

  // Keys come mostly from a small pool, so that searches and replaces hit.
  function automatic logic [31:0] pick_word();
    logic [31:0] pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                              32'hffff_ffff, 32'h0000_0005, 32'h0000_002a};
    if ($urandom_range(0, 99) < 60) begin
      return pool[$urandom_range(0, 5)];
    end
    return $urandom();
  endfunction

  // Appends outweigh removals so that the store often fills; a full store is
  // cleared now and then so that the fill level sweeps its whole range.
  function automatic logic [2:0] pick_action();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (store_sb.fill == DEPTH && roll < 15) return ACT_CLEAR;
    roll = $urandom_range(0, 99);
    if (roll < 38) return ACT_APPEND;
    if (roll < 48) return ACT_REMOVE;
    if (roll < 63) return ACT_SEARCH;
    if (roll < 68) return ACT_COUNT;
    if (roll < 80) return ACT_REPLACE;
    if (roll < 93) return ACT_LIST;
    if (roll < 95) return ACT_CLEAR;
    if (roll < 97) return ACT_UNUSED;
    return ACT_SEARCH;
  endfunction

  // Stimulus: directed cases, then random items, then the final check.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Every operation but append on an empty store, and the unused code.
    send_item(ACT_REMOVE, 32'h0, 32'h0);
    send_item(ACT_SEARCH, 32'h0, 32'h0);
    send_item(ACT_LIST, 32'h0, 32'h0);
    send_item(ACT_REPLACE, 32'h0, 32'h1);
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    send_item(ACT_COUNT, 32'h0, 32'h0);
    send_item(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff);

    // Extreme words, with a duplicate so that a search matches twice.
    send_item(ACT_APPEND, 32'h8000_0000, 32'h0);
    send_item(ACT_APPEND, 32'h7fff_ffff, 32'h0);
    send_item(ACT_APPEND, 32'hffff_ffff, 32'h0);
    send_item(ACT_APPEND, 32'h7fff_ffff, 32'h0);
    send_item(ACT_SEARCH, 32'h7fff_ffff, 32'h0);
    send_item(ACT_SEARCH, 32'h0001_2345, 32'h0);
    send_item(ACT_REPLACE, 32'h7fff_ffff, 32'h8000_0000);
    send_item(ACT_REPLACE, 32'h0001_2345, 32'h0);
    send_item(ACT_LIST, 32'h0, 32'h0);
    send_item(ACT_REMOVE, 32'h0, 32'h0);

    // Fill the store, try one append too many, then scan it whole.
    while (store_sb.fill < DEPTH) send_item(ACT_APPEND, pick_word(), 32'h0);
    send_item(ACT_APPEND, 32'h1, 32'h0);
    send_item(ACT_SEARCH, 32'h8000_0000, 32'h0);
    send_item(ACT_LIST, 32'h0, 32'h0);
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= 200 && n < 300);
      if (n == 120 || n == 360) drain_results();
      send_item(pick_action(), pick_word(), pick_word());
    end
    steady_phase = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (store_sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
